// ===== sv/esc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Widths, register indexes, scheme constants and shift helpers.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int REQ_W      = 56;
   localparam int RSP_W      = 88;
   localparam int HUM_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CAL_W      = 48;
   localparam int DIV_STEPS  = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_CAL       = 3'd0,
      CSR_PRES_CAL_FIRST = 3'd1,
      CSR_PRES_CAL_MID   = 3'd2,
      CSR_PRES_CAL_LAST  = 3'd3,
      CSR_HUM_CAL        = 3'd4
   } csr_index_type;

   localparam logic [31:0] T_ROUND    = 32'd128;
   localparam logic [63:0] P_OFFSET   = 64'd128000;
   localparam logic [63:0] ADC_P_BASE = 64'd1048576;
   localparam logic [63:0] P_SCALE    = 64'd3125;
   localparam logic [63:0] P_ONE_47   = 64'd1 << 47;
   localparam logic [31:0] H_OFFSET   = 32'd76800;
   localparam logic [31:0] H_CLAMP    = 32'd419430400;
   localparam logic [31:0] H_ADD_D    = 32'd2097152;
   localparam logic [31:0] H_ADD_C    = 32'd32768;
   localparam logic [31:0] H_ROUND_A  = 32'd16384;
   localparam logic [31:0] H_ROUND_D  = 32'd8192;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
      return 64'($signed(x) >>> s);
   endfunction

endpackage

// ===== sv/env_sensor_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Environmental sensor compensation
// Integer temperature, pressure and humidity compensation of one raw triple.
// ----------------------------------------------------------------------------
// req_* takes one raw triple per item; rsp_* gives one compensated triple per
// item, in order. Calibration words must be written through csr_* only while
// no item is in flight; the block does not enforce it. Indexes beyond the last
// register are ignored. One item enters per cycle while no stall holds the
// pipeline; the 64-step pressure divider pipeline and the 64-bit multipliers,
// each split into two stages, set the depth.
// Reset clears all valid bits and the calibration registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_tready drops; bubbles in flight are not squeezed out.
// pressure_valid travels on rsp_tuser; a zero divisor gives pressure zero.
// ----------------------------------------------------------------------------
module env_sensor_compensation
   import esc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // temperature_centideg[31:0], pressure_q24_8[63:32], humidity_q7_10[80:64]
   output logic [RSP_W-1:0]      rsp_tdata,
   // pressure_valid[0]
   output logic                  rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int N = 86;

   logic [CAL_W-1:0]      cal_t_ff, cal_p1_ff, cal_p2_ff, cal_p3_ff;
   logic [CSR_DATA_W-1:0] cal_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_p1_ff <= '0;
         cal_p2_ff <= '0;
         cal_p3_ff <= '0;
         cal_h_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_CAL:       cal_t_ff  <= csr_wdata[CAL_W-1:0];
            CSR_PRES_CAL_FIRST: cal_p1_ff <= csr_wdata[CAL_W-1:0];
            CSR_PRES_CAL_MID:   cal_p2_ff <= csr_wdata[CAL_W-1:0];
            CSR_PRES_CAL_LAST:  cal_p3_ff <= csr_wdata[CAL_W-1:0];
            CSR_HUM_CAL:        cal_h_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = {16'd0, cal_t_ff[15:0]};
   assign t2 = {{16{cal_t_ff[31]}}, cal_t_ff[31:16]};
   assign t3 = {{16{cal_t_ff[47]}}, cal_t_ff[47:32]};
   assign p1 = {48'd0, cal_p1_ff[15:0]};
   assign p2 = {{48{cal_p1_ff[31]}}, cal_p1_ff[31:16]};
   assign p3 = {{48{cal_p1_ff[47]}}, cal_p1_ff[47:32]};
   assign p4 = {{48{cal_p2_ff[15]}}, cal_p2_ff[15:0]};
   assign p5 = {{48{cal_p2_ff[31]}}, cal_p2_ff[31:16]};
   assign p6 = {{48{cal_p2_ff[47]}}, cal_p2_ff[47:32]};
   assign p7 = {{48{cal_p3_ff[15]}}, cal_p3_ff[15:0]};
   assign p8 = {{48{cal_p3_ff[31]}}, cal_p3_ff[31:16]};
   assign p9 = {{48{cal_p3_ff[47]}}, cal_p3_ff[47:32]};
   assign h1 = {24'd0, cal_h_ff[7:0]};
   assign h2 = {{16{cal_h_ff[23]}}, cal_h_ff[23:8]};
   assign h3 = {24'd0, cal_h_ff[31:24]};
   assign h4 = {{20{cal_h_ff[43]}}, cal_h_ff[43:32]};
   assign h5 = {{20{cal_h_ff[55]}}, cal_h_ff[55:44]};
   assign h6 = {{24{cal_h_ff[63]}}, cal_h_ff[63:56]};

   logic en;
   logic vld_ff [1:N];

   assign en         = !vld_ff[N] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= N; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= N; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // temperature
   logic [31:0] adc_t, td;
   logic [31:0] ta_in, dd_in, a2_in, tb2_in, tf3_in, temp4_in;
   logic [31:0] ta1_ff, dd1_ff, a2_ff, tb2_ff, tf3_ff;
   logic [31:0] temp_ff [4:N];
   logic [19:0] ap_ff [1:9];
   logic [15:0] ah_ff [1:4];

   assign adc_t    = {12'd0, req_tdata[19:0]};
   assign td       = (adc_t >> 4) - t1;
   assign ta_in    = ((adc_t >> 3) - (t1 << 1)) * t2;
   assign dd_in    = td * td;
   assign a2_in    = asr32(ta1_ff, 11);
   assign tb2_in   = asr32(dd1_ff, 12) * t3;
   assign tf3_in   = a2_ff + asr32(tb2_ff, 14);
   assign temp4_in = asr32(tf3_ff * 32'd5 + T_ROUND, 8);

   // pressure front
   logic [63:0] x1_4_in, x1_4_ff, xx, m2, m3, m4, m5, m6, m7;
   logic [63:0] m2_ff [7:8];
   logic [63:0] m3_ff [7:8];
   logic [63:0] x2_9_in, x1b_9_in, x2_9_ff, x1b_9_ff;
   logic [63:0] pn, num10_in, x1c10_in, num10_ff, x1c10_ff;
   logic [63:0] den13_ff, num13_ff;
   logic        dz_ff [13:85];

   assign x1_4_in  = {{32{tf3_ff[31]}}, tf3_ff} - P_OFFSET;
   assign x2_9_in  = m4 + (m2_ff[8] << 17) + (p4 << 35);
   assign x1b_9_in = asr64(m5, 8) + (m3_ff[8] << 12);
   assign pn       = ADC_P_BASE - {44'd0, ap_ff[9]};
   assign num10_in = (pn << 31) - x2_9_ff;
   assign x1c10_in = P_ONE_47 + x1b_9_ff;

   esc_mul64 u_mul_xx (.clock, .en, .a(x1_4_ff), .b(x1_4_ff), .prod(xx));
   esc_mul64 u_mul_p5 (.clock, .en, .a(x1_4_ff), .b(p5),      .prod(m2));
   esc_mul64 u_mul_p2 (.clock, .en, .a(x1_4_ff), .b(p2),      .prod(m3));
   esc_mul64 u_mul_p6 (.clock, .en, .a(xx),      .b(p6),      .prod(m4));
   esc_mul64 u_mul_p3 (.clock, .en, .a(xx),      .b(p3),      .prod(m5));
   esc_mul64 u_mul_p1 (.clock, .en, .a(x1c10_ff), .b(p1),     .prod(m6));
   esc_mul64 u_mul_sc (.clock, .en, .a(num10_ff), .b(P_SCALE), .prod(m7));

   // division and pressure back end
   logic [63:0] q;
   logic [63:0] qs80_in, m8, m9, m10;
   logic [63:0] qs_ff  [80:81];
   logic [63:0] q_ff   [80:83];
   logic [63:0] m10_ff [82:83];
   logic [63:0] s84_in, s84_ff, pf85_in, pf85_ff;
   logic [31:0] pres_in, pres_ff;
   logic        pvld_ff;

   esc_div u_div (.clock, .en, .num(num13_ff), .den(den13_ff), .quo(q));

   assign qs80_in = asr64(q, 13);

   esc_mul64 u_mul_p9 (.clock, .en, .a(p9),    .b(qs80_in),   .prod(m8));
   esc_mul64 u_mul_p8 (.clock, .en, .a(p8),    .b(q),         .prod(m10));
   esc_mul64 u_mul_qs (.clock, .en, .a(m8),    .b(qs_ff[81]), .prod(m9));

   assign s84_in  = q_ff[83] + asr64(m9, 25) + asr64(m10_ff[83], 19);
   assign pf85_in = asr64(s84_ff, 8) + (p7 << 4);

   always_comb begin
      if (dz_ff[85]) begin
         pres_in = '0;
      end else if (pf85_ff[63:31] == '0 || pf85_ff[63:31] == '1) begin
         pres_in = pf85_ff[31:0];
      end else begin
         pres_in = pf85_ff[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   end

   // humidity
   logic [31:0] hv4_in, hv4_ff;
   logic [31:0] ha5_in, hb5_in, hd5_in, ha5_ff, hb5_ff, hd5_ff;
   logic [31:0] b6_in, d6_in, b6_ff, d6_ff;
   logic [31:0] ha_ff [6:10];
   logic [31:0] bd7_ff, d8_in, d8_ff, d9_ff, d10_in, d10_ff;
   logic [31:0] hm_ff [11:14];
   logic [31:0] f12_in, f12_ff, ff13_ff, g14_in, g14_ff, hr15_in, hr15_ff, hc;
   logic [HUM_W-1:0] hum_ff [16:N];

   assign hv4_in  = tf3_ff - H_OFFSET;
   assign ha5_in  = ({16'd0, ah_ff[4]} << 14) - (h4 << 20) - h5 * hv4_ff + H_ROUND_A;
   assign hb5_in  = hv4_ff * h6;
   assign hd5_in  = hv4_ff * h3;
   assign b6_in   = asr32(hb5_ff, 10);
   assign d6_in   = asr32(hd5_ff, 11) + H_ADD_C;
   assign d8_in   = asr32(bd7_ff, 10) + H_ADD_D;
   assign d10_in  = asr32(d9_ff + H_ROUND_D, 14);
   assign f12_in  = asr32(hm_ff[11], 15);
   assign g14_in  = asr32(ff13_ff, 7) * h1;
   assign hr15_in = hm_ff[14] - asr32(g14_ff, 4);

   always_comb begin
      if (hr15_ff[31]) begin
         hc = '0;
      end else if (hr15_ff > H_CLAMP) begin
         hc = H_CLAMP;
      end else begin
         hc = hr15_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ta1_ff <= ta_in;
         dd1_ff <= dd_in;
         a2_ff  <= a2_in;
         tb2_ff <= tb2_in;
         tf3_ff <= tf3_in;
         temp_ff[4] <= temp4_in;
         for (int k = 5; k <= N; k++) temp_ff[k] <= temp_ff[k-1];
         ap_ff[1] <= req_tdata[39:20];
         for (int k = 2; k <= 9; k++) ap_ff[k] <= ap_ff[k-1];
         ah_ff[1] <= req_tdata[55:40];
         for (int k = 2; k <= 4; k++) ah_ff[k] <= ah_ff[k-1];

         x1_4_ff  <= x1_4_in;
         m2_ff[7] <= m2;
         m2_ff[8] <= m2_ff[7];
         m3_ff[7] <= m3;
         m3_ff[8] <= m3_ff[7];
         x2_9_ff  <= x2_9_in;
         x1b_9_ff <= x1b_9_in;
         num10_ff <= num10_in;
         x1c10_ff <= x1c10_in;
         den13_ff <= asr64(m6, 33);
         num13_ff <= m7;
         dz_ff[13] <= (m6[63:33] == '0);
         for (int k = 14; k <= 85; k++) dz_ff[k] <= dz_ff[k-1];

         qs_ff[80] <= qs80_in;
         qs_ff[81] <= qs_ff[80];
         q_ff[80]  <= q;
         for (int k = 81; k <= 83; k++) q_ff[k] <= q_ff[k-1];
         m10_ff[82] <= m10;
         m10_ff[83] <= m10_ff[82];
         s84_ff  <= s84_in;
         pf85_ff <= pf85_in;
         pres_ff <= pres_in;
         pvld_ff <= !dz_ff[85];

         hv4_ff <= hv4_in;
         ha5_ff <= ha5_in;
         hb5_ff <= hb5_in;
         hd5_ff <= hd5_in;
         ha_ff[6] <= asr32(ha5_ff, 15);
         for (int k = 7; k <= 10; k++) ha_ff[k] <= ha_ff[k-1];
         b6_ff  <= b6_in;
         d6_ff  <= d6_in;
         bd7_ff <= b6_ff * d6_ff;
         d8_ff  <= d8_in;
         d9_ff  <= d8_ff * h2;
         d10_ff <= d10_in;
         hm_ff[11] <= ha_ff[10] * d10_ff;
         for (int k = 12; k <= 14; k++) hm_ff[k] <= hm_ff[k-1];
         f12_ff  <= f12_in;
         ff13_ff <= f12_ff * f12_ff;
         g14_ff  <= g14_in;
         hr15_ff <= hr15_in;
         hum_ff[16] <= hc[28:12];
         for (int k = 17; k <= N; k++) hum_ff[k] <= hum_ff[k-1];
      end
   end

   assign rsp_tvalid = vld_ff[N];
   assign rsp_tdata  = {7'd0, hum_ff[N], pres_ff, temp_ff[N]};
   assign rsp_tuser  = pvld_ff;

`ifndef SYNTHESIS
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   a_invalid_pressure_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[63:32] == 32'd0)
      else $error("pressure nonzero with zero divisor");

   a_humidity_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[80:64] <= 17'd102400)
      else $error("humidity above clamp");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== sv/esc_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 64-bit wrapping multiplier
// Low 64 bits of a product from three 32x32 partial products, two stages.
// ----------------------------------------------------------------------------
module esc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] prod
);

   logic [63:0] ll_ff;
   logic [31:0] cross_ff;
   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= 64'(a[31:0]) * 64'(b[31:0]);
         cross_ff <= 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
         prod_ff  <= ll_ff + {cross_ff, 32'd0};
      end
   end

   assign prod = prod_ff;

endmodule

// ===== sv/esc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed 64-bit divider
// Truncating quotient, one restoring step per stage.
// ----------------------------------------------------------------------------
module esc_div
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] quo
);

   logic [63:0] mn_ff, md_ff;
   logic        neg_ff;
   logic [63:0] rem_ff [DIV_STEPS];
   logic [63:0] qn_ff  [DIV_STEPS];
   logic [63:0] dv_ff  [DIV_STEPS];
   logic        ng_ff  [DIV_STEPS];
   logic [63:0] rem_in [DIV_STEPS];
   logic [63:0] qn_in  [DIV_STEPS];
   logic [63:0] rem_src [DIV_STEPS];
   logic [63:0] qn_src  [DIV_STEPS];
   logic [63:0] dv_src  [DIV_STEPS];
   logic [64:0] trial   [DIV_STEPS];
   logic [63:0] quo_ff;

   always_comb begin
      rem_src[0] = '0;
      qn_src[0]  = mn_ff;
      dv_src[0]  = md_ff;
      for (int k = 1; k < DIV_STEPS; k++) begin
         rem_src[k] = rem_ff[k-1];
         qn_src[k]  = qn_ff[k-1];
         dv_src[k]  = dv_ff[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial[k] = {rem_src[k], qn_src[k][63]};
         if (trial[k] >= {1'b0, dv_src[k]}) begin
            rem_in[k] = 64'(trial[k] - {1'b0, dv_src[k]});
            qn_in[k]  = {qn_src[k][62:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][63:0];
            qn_in[k]  = {qn_src[k][62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mn_ff  <= num[63] ? 64'(64'd0 - num) : num;
         md_ff  <= den[63] ? 64'(64'd0 - den) : den;
         neg_ff <= num[63] ^ den[63];
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            qn_ff[k]  <= qn_in[k];
         end
         dv_ff[0] <= md_ff;
         ng_ff[0] <= neg_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
            ng_ff[k] <= ng_ff[k-1];
         end
         quo_ff <= ng_ff[DIV_STEPS-1] ? 64'(64'd0 - qn_ff[DIV_STEPS-1])
                                      : qn_ff[DIV_STEPS-1];
      end
   end

   assign quo = quo_ff;

endmodule
